// ----- design/stsmc_pkg.sv -----
`default_nettype none
package stsmc_pkg;

	localparam int CFG_DW  = 32;
	localparam int CFG_IW  = 3;
	localparam int GAIN_W  = 32;
	localparam int UCFG_W  = 31;

	typedef enum logic [CFG_IW-1:0] {
		REG_MODE    = 3'd0,
		REG_SLOPE   = 3'd1,
		REG_SOFTEN  = 3'd2,
		REG_PERIOD  = 3'd3,
		REG_INVPER  = 3'd4,
		REG_RGAIN   = 3'd5,
		REG_IGAIN   = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_RATE       = 4'd0,
		OP_SLOPE_ERR  = 4'd1,
		OP_ACC        = 4'd2,
		OP_SLOPE_RATE = 4'd3,
		OP_SLOPE_SQ   = 4'd4,
		OP_L2_ERR     = 4'd5,
		OP_INTEG      = 4'd6,
		OP_ROOT       = 4'd7,
		OP_FORCE      = 4'd8,
		OP_SMOOTH     = 4'd9
	} mul_op_t;

	typedef struct packed {
		logic    accept;
		logic    err_en;
		logic    mul_go;
		logic    mul_hi;
		logic    mul_wb;
		mul_op_t mul_op;
		logic    sum_en;
		logic    div_load;
		logic    div_step;
		logic    div_sel;
		logic    sqrt_load;
		logic    sqrt_step;
		logic    drive_en;
	} cmd_t;

	typedef struct packed {
		logic mode;
	} sts_t;

endpackage
`default_nettype wire

// ----- design/stsmc_sdiv.sv -----
`default_nettype none
// Restoring divider for the smoothed sign |x| * 2^F / (|x| + eps), one bit a step.
module stsmc_sdiv #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          load,
	input  wire logic                          step,
	input  wire logic signed [DATA_WIDTH-1:0]  x,
	input  wire logic [stsmc_pkg::UCFG_W-1:0]  eps,
	output logic signed [FRAC_BITS:0]          res
);
	localparam int DW = ((DATA_WIDTH > stsmc_pkg::UCFG_W) ?
		DATA_WIDTH : stsmc_pkg::UCFG_W) + 1;

	logic [DW-1:0]        r_q, d_q;
	logic [FRAC_BITS-1:0] q_q;
	logic                 neg_q, zero_q;
	logic [DATA_WIDTH-1:0] xm;
	logic [DW-1:0]        dsum;
	logic [DW:0]          sh, diff;

	assign xm   = x[DATA_WIDTH-1] ? DATA_WIDTH'(-x) : DATA_WIDTH'(x);
	assign dsum = DW'(xm) + DW'(eps);
	assign sh   = {r_q, 1'b0};
	assign diff = sh - {1'b0, d_q};

	always_ff @(posedge clk) begin
		if (load) begin
			r_q    <= DW'(xm);
			d_q    <= dsum;
			q_q    <= '0;
			neg_q  <= x[DATA_WIDTH-1];
			zero_q <= (dsum == '0);
		end else if (step) begin
			if (sh >= {1'b0, d_q}) begin
				r_q <= diff[DW-1:0];
				q_q <= {q_q[FRAC_BITS-2:0], 1'b1};
			end else begin
				r_q <= sh[DW-1:0];
				q_q <= {q_q[FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (zero_q)
			res = '0;
		else if (neg_q)
			res = -$signed({1'b0, q_q});
		else
			res = $signed({1'b0, q_q});
	end
endmodule
`default_nettype wire

// ----- design/stsmc_sqrt.sv -----
`default_nettype none
// Digit-by-digit square root of v * 2^F, one bit pair a step.
module stsmc_sqrt #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   load,
	input  wire logic                                   step,
	input  wire logic [DATA_WIDTH-1:0]                  v,
	output logic [(DATA_WIDTH+FRAC_BITS+1)/2-1:0]       root
);
	localparam int NP  = (DATA_WIDTH + FRAC_BITS + 1) / 2;
	localparam int RW  = 2 * NP;
	localparam int RMW = NP + 2;

	logic [RW-1:0]  rad_q;
	logic [RMW-1:0] rem_q;
	logic [NP-1:0]  root_q;
	logic [RMW+1:0] cat, trial, sub;

	assign cat   = {rem_q, rad_q[RW-1:RW-2]};
	assign trial = (RMW+2)'({root_q, 2'b01});
	assign sub   = cat - trial;
	assign root  = root_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rad_q  <= RW'({v, {FRAC_BITS{1'b0}}});
			rem_q  <= '0;
			root_q <= '0;
		end else if (step) begin
			rad_q <= {rad_q[RW-3:0], 2'b00};
			if (cat >= trial) begin
				rem_q  <= sub[RMW-1:0];
				root_q <= {root_q[NP-2:0], 1'b1};
			end else begin
				rem_q  <= cat[RMW-1:0];
				root_q <= {root_q[NP-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ----- design/stsmc_dp.sv -----
`default_nettype none
module stsmc_dp #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire stsmc_pkg::cmd_t                      cmd,
	output stsmc_pkg::sts_t                           sts,
	input  wire logic                                 cfg_we,
	input  wire logic [stsmc_pkg::CFG_IW-1:0]         cfg_index,
	input  wire logic [stsmc_pkg::CFG_DW-1:0]         cfg_data,
	input  wire logic signed [DATA_WIDTH-1:0]         target_value,
	input  wire logic signed [DATA_WIDTH-1:0]         measured_value,
	input  wire logic [stsmc_pkg::UCFG_W-1:0]         output_limit,
	output logic signed [DATA_WIDTH-1:0]              drive_value
);
	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int IW  = W + 8;
	localparam int MW  = (IW > stsmc_pkg::GAIN_W + 1) ? IW : stsmc_pkg::GAIN_W + 1;
	localparam int HB  = (MW + 1) / 2;
	localparam int XW  = 2 * MW + 1;
	localparam int NP  = (W + F + 1) / 2;
	localparam logic signed [XW-1:0] MAXW  = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] MINW  = ~MAXW;
	localparam logic signed [XW-1:0] MAXIW = {{(XW-IW+1){1'b0}}, {(IW-1){1'b1}}};
	localparam logic signed [XW-1:0] MINIW = ~MAXIW;

	function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
		if (v > MAXW)      return MAXW[W-1:0];
		else if (v < MINW) return MINW[W-1:0];
		else               return v[W-1:0];
	endfunction

	function automatic logic signed [IW-1:0] sat_iw(input logic signed [XW-1:0] v);
		if (v > MAXIW)      return MAXIW[IW-1:0];
		else if (v < MINIW) return MINIW[IW-1:0];
		else                return v[IW-1:0];
	endfunction

	// configuration
	logic                                mode_q;
	logic signed [stsmc_pkg::GAIN_W-1:0] slope_q, igain_q;
	logic [stsmc_pkg::UCFG_W-1:0]        eps_q, period_q, invper_q, rgain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			slope_q  <= 32'sd65536;
			eps_q    <= 31'd655;
			period_q <= 31'd65;
			invper_q <= 31'd65536000;
			rgain_q  <= 31'd65536;
			igain_q  <= 32'sd72090;
		end else if (cfg_we) begin
			unique case (stsmc_pkg::cfg_reg_t'(cfg_index))
				stsmc_pkg::REG_MODE:   mode_q   <= cfg_data[0];
				stsmc_pkg::REG_SLOPE:  slope_q  <= $signed(cfg_data);
				stsmc_pkg::REG_SOFTEN: eps_q    <= cfg_data[stsmc_pkg::UCFG_W-1:0];
				stsmc_pkg::REG_PERIOD: period_q <= cfg_data[stsmc_pkg::UCFG_W-1:0];
				stsmc_pkg::REG_INVPER: invper_q <= cfg_data[stsmc_pkg::UCFG_W-1:0];
				stsmc_pkg::REG_RGAIN:  rgain_q  <= cfg_data[stsmc_pkg::UCFG_W-1:0];
				stsmc_pkg::REG_IGAIN:  igain_q  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign sts.mode = mode_q;

	// controller state carried between items
	logic signed [W-1:0]  last_err_q, last_rate_q, last_surf_q;
	logic signed [IW-1:0] integ_q;

	// per-item working registers
	logic signed [W-1:0] tgt_q, meas_q;
	logic [stsmc_pkg::UCFG_W-1:0] lim_q;
	logic signed [W-1:0] err_q, diff_q, rate_q, acc_q, t2_q, l2_q, t3_q, surf_q;
	logic signed [W-1:0] force_q, smooth_q;
	logic signed [F:0]   gold_q, gs_q;

	// iterative units
	logic signed [F:0]  div_res;
	logic [NP-1:0]      sq_root;
	logic signed [W-1:0] div_x;
	logic [W-1:0]       surf_mag;

	assign div_x    = cmd.div_sel ? surf_q : last_surf_q;
	assign surf_mag = surf_q[W-1] ? W'(-surf_q) : W'(surf_q);

	stsmc_sdiv #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_sdiv (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.x    (div_x),
		.eps  (eps_q),
		.res  (div_res)
	);

	stsmc_sqrt #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_sqrt (
		.clk  (clk),
		.load (cmd.sqrt_load),
		.step (cmd.sqrt_step),
		.v    (surf_mag),
		.root (sq_root)
	);

	// shared multiplier: magnitudes multiplied, operand b in two half-width
	// passes (low half, then high half added in), product registered
	logic signed [MW-1:0] op_a, op_b;
	logic signed [F+1:0]  gsum;
	logic [MW-1:0]        mag_a, mag_b;
	logic [2*HB-1:0]      mag_bx;
	logic [HB-1:0]        b_part;
	logic [MW+HB-1:0]     pp;
	logic [2*MW-1:0]      prod_q, prod_sh;
	logic                 neg_q;
	logic signed [XW-1:0] mres;
	logic signed [W-1:0]  mres_w;
	logic signed [IW-1:0] mres_iw;

	assign gsum = (F+2)'(gold_q) + (F+2)'(div_res);

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.mul_op)
			stsmc_pkg::OP_RATE: begin
				op_a = MW'(diff_q);
				op_b = MW'($signed({1'b0, invper_q}));
			end
			stsmc_pkg::OP_SLOPE_ERR: begin
				op_a = MW'(slope_q);
				op_b = MW'(err_q);
			end
			stsmc_pkg::OP_ACC: begin
				op_a = MW'(sat_w(XW'(rate_q) - XW'(last_rate_q)));
				op_b = MW'($signed({1'b0, invper_q}));
			end
			stsmc_pkg::OP_SLOPE_RATE: begin
				op_a = MW'(slope_q);
				op_b = MW'(rate_q);
			end
			stsmc_pkg::OP_SLOPE_SQ: begin
				op_a = MW'(slope_q);
				op_b = MW'(slope_q);
			end
			stsmc_pkg::OP_L2_ERR: begin
				op_a = MW'(l2_q);
				op_b = MW'(err_q);
			end
			stsmc_pkg::OP_INTEG: begin
				op_a = MW'(gsum);
				op_b = MW'($signed({1'b0, period_q}));
			end
			stsmc_pkg::OP_ROOT: begin
				op_a = MW'($signed({1'b0, rgain_q}));
				op_b = MW'($signed({1'b0, sq_root}));
			end
			stsmc_pkg::OP_FORCE: begin
				op_a = MW'(force_q);
				op_b = MW'(gs_q);
			end
			stsmc_pkg::OP_SMOOTH: begin
				op_a = MW'(igain_q);
				op_b = MW'(integ_q);
			end
			default: ;
		endcase
	end

	assign mag_a  = op_a[MW-1] ? MW'(-op_a) : MW'(op_a);
	assign mag_b  = op_b[MW-1] ? MW'(-op_b) : MW'(op_b);
	assign mag_bx = (2*HB)'(mag_b);
	assign b_part = cmd.mul_hi ? mag_bx[2*HB-1:HB] : mag_bx[HB-1:0];
	assign pp     = mag_a * b_part;

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod_q <= (2*MW)'(pp);
			neg_q  <= op_a[MW-1] ^ op_b[MW-1];
		end else if (cmd.mul_hi) begin
			prod_q <= prod_q + ((2*MW)'(pp) << HB);
		end
	end

	// the integral step carries the halving of the trapezoid in its shift
	assign prod_sh = (cmd.mul_op == stsmc_pkg::OP_INTEG) ? (prod_q >> (F + 1)) : (prod_q >> F);
	assign mres    = neg_q ? -$signed({1'b0, prod_sh}) : $signed({1'b0, prod_sh});
	assign mres_w  = sat_w(mres);
	assign mres_iw = sat_iw(mres);

	// drive clamp
	logic signed [XW-1:0] dsum, limx, dclamp;
	always_comb begin
		dsum = XW'(sat_w(XW'(force_q) + XW'(smooth_q)));
		limx = XW'($signed({1'b0, lim_q}));
		if (dsum >= limx)       dclamp = limx;
		else if (dsum <= -limx) dclamp = -limx;
		else                    dclamp = dsum;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			tgt_q  <= target_value;
			meas_q <= measured_value;
			lim_q  <= output_limit;
		end
		if (cmd.err_en) begin
			err_q  <= sat_w(XW'(tgt_q) - XW'(meas_q));
			diff_q <= sat_w(XW'(sat_w(XW'(tgt_q) - XW'(meas_q))) - XW'(last_err_q));
		end
		if (cmd.mul_wb) begin
			case (cmd.mul_op)
				stsmc_pkg::OP_RATE:       rate_q   <= mres_w;
				stsmc_pkg::OP_SLOPE_ERR:  t2_q     <= mres_w;
				stsmc_pkg::OP_ACC:        acc_q    <= mres_w;
				stsmc_pkg::OP_SLOPE_RATE: t2_q     <= sat_w(XW'(mres_w) <<< 1);
				stsmc_pkg::OP_SLOPE_SQ:   l2_q     <= mres_w;
				stsmc_pkg::OP_L2_ERR:     t3_q     <= mres_w;
				stsmc_pkg::OP_ROOT:       force_q  <= mres_w;
				stsmc_pkg::OP_FORCE:      force_q  <= mres_w;
				stsmc_pkg::OP_SMOOTH:     smooth_q <= mres_w;
				default: ;
			endcase
		end
		if (cmd.sum_en) begin
			if (mode_q)
				surf_q <= sat_w(XW'(sat_w(XW'(acc_q) + XW'(t2_q))) + XW'(t3_q));
			else
				surf_q <= sat_w(XW'(rate_q) + XW'(t2_q));
		end
		// old-surface sign is ready once the second pass loads
		if (cmd.div_load && cmd.div_sel)
			gold_q <= div_res;
		if (cmd.mul_go && (cmd.mul_op == stsmc_pkg::OP_INTEG))
			gs_q <= div_res;
		if (cmd.drive_en)
			drive_value <= sat_w(dclamp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q  <= '0;
			last_rate_q <= '0;
			last_surf_q <= '0;
			integ_q     <= '0;
		end else begin
			if (cmd.mul_wb && (cmd.mul_op == stsmc_pkg::OP_INTEG))
				integ_q <= sat_iw(XW'(integ_q) + XW'(mres_iw));
			if (cmd.drive_en) begin
				last_err_q  <= err_q;
				last_rate_q <= rate_q;
				last_surf_q <= surf_q;
			end
		end
	end
endmodule
`default_nettype wire

// ----- design/stsmc_ctrl.sv -----
`default_nettype none
module stsmc_ctrl #(
	parameter int FRAC_BITS = 16,
	parameter int SQ_STEPS  = 24
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire stsmc_pkg::sts_t sts,
	output stsmc_pkg::cmd_t      cmd
);
	localparam int MAXC = (FRAC_BITS > SQ_STEPS) ? FRAC_BITS : SQ_STEPS;
	localparam int CW   = $clog2(MAXC);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_ERR  = 11'b00000000010,
		S_MUL  = 11'b00000000100,
		S_MHI  = 11'b00000001000,
		S_MWB  = 11'b00000010000,
		S_SUM  = 11'b00000100000,
		S_DLD  = 11'b00001000000,
		S_DRUN = 11'b00010000000,
		S_SLD  = 11'b00100000000,
		S_SRUN = 11'b01000000000,
		S_DRV  = 11'b10000000000
	} state_t;

	state_t             state_q, state_n;
	stsmc_pkg::mul_op_t op_q, op_n;
	logic [CW-1:0]      cnt_q, cnt_n;
	logic               sel_q, sel_n;
	logic               ov_q, ov_n;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		state_n = state_q;
		op_n    = op_q;
		cnt_n   = cnt_q;
		sel_n   = sel_q;
		ov_n    = ov_q && !out_ready;
		cmd     = '0;
		cmd.mul_op  = op_q;
		cmd.div_sel = sel_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) state_n = S_ERR;
			end
			S_ERR: begin
				cmd.err_en = 1'b1;
				op_n       = stsmc_pkg::OP_RATE;
				state_n    = S_MUL;
			end
			S_MUL: begin
				cmd.mul_go = 1'b1;
				state_n    = S_MHI;
			end
			S_MHI: begin
				cmd.mul_hi = 1'b1;
				state_n    = S_MWB;
			end
			S_MWB: begin
				cmd.mul_wb = 1'b1;
				state_n    = S_MUL;
				unique case (op_q)
					stsmc_pkg::OP_RATE:
						op_n = sts.mode ? stsmc_pkg::OP_ACC : stsmc_pkg::OP_SLOPE_ERR;
					stsmc_pkg::OP_ACC:        op_n = stsmc_pkg::OP_SLOPE_RATE;
					stsmc_pkg::OP_SLOPE_RATE: op_n = stsmc_pkg::OP_SLOPE_SQ;
					stsmc_pkg::OP_SLOPE_SQ:   op_n = stsmc_pkg::OP_L2_ERR;
					stsmc_pkg::OP_SLOPE_ERR,
					stsmc_pkg::OP_L2_ERR:     state_n = S_SUM;
					stsmc_pkg::OP_INTEG:      state_n = S_SLD;
					stsmc_pkg::OP_ROOT:       op_n = stsmc_pkg::OP_FORCE;
					stsmc_pkg::OP_FORCE:      op_n = stsmc_pkg::OP_SMOOTH;
					stsmc_pkg::OP_SMOOTH:     state_n = S_DRV;
					default:                  state_n = S_IDLE;
				endcase
			end
			S_SUM: begin
				cmd.sum_en = 1'b1;
				sel_n      = 1'b0;
				state_n    = S_DLD;
			end
			S_DLD: begin
				cmd.div_load = 1'b1;
				cnt_n        = '0;
				state_n      = S_DRUN;
			end
			S_DRUN: begin
				cmd.div_step = 1'b1;
				cnt_n        = cnt_q + 1'b1;
				if (cnt_q == CW'(FRAC_BITS - 1)) begin
					if (!sel_q) begin
						sel_n   = 1'b1;
						state_n = S_DLD;
					end else begin
						op_n    = stsmc_pkg::OP_INTEG;
						state_n = S_MUL;
					end
				end
			end
			S_SLD: begin
				cmd.sqrt_load = 1'b1;
				cnt_n         = '0;
				state_n       = S_SRUN;
			end
			S_SRUN: begin
				cmd.sqrt_step = 1'b1;
				cnt_n         = cnt_q + 1'b1;
				if (cnt_q == CW'(SQ_STEPS - 1)) begin
					op_n    = stsmc_pkg::OP_ROOT;
					state_n = S_MUL;
				end
			end
			S_DRV: begin
				if (!ov_q || out_ready) begin
					cmd.drive_en = 1'b1;
					ov_n         = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= stsmc_pkg::OP_RATE;
			cnt_q   <= '0;
			sel_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			op_q    <= op_n;
			cnt_q   <= cnt_n;
			sel_q   <= sel_n;
			ov_q    <= ov_n;
		end
	end
endmodule
`default_nettype wire

// ----- design/super_twisting_smc_step_core.sv -----
// Super-twisting sliding-mode controller, one control step per transfer.
// Input channel (in_valid/in_ready): target_value, measured_value (signed
// Q16.16) and output_limit (unsigned Q15.16) at default widths. One transfer in
// gives exactly one drive_value transfer out (out_valid/out_ready).
// Configuration: cfg_we/cfg_index/cfg_data write one register per clock,
// no wait; write only while the block is idle.
// Work is set by one shared multiplier (each product two half-width passes
// and a write-back), a bit-serial divider run twice for the smoothed sign
// and a bit-pair square-root unit; position mode takes three more products
// than speed mode. One item is worked at a time; in_ready is high only
// while the controller is idle, so a new transfer is taken only once the
// drive of the last item has been registered.
// The result sits in an output register, so a new transfer is taken while
// the last drive waits; a stalled receiver holds the block only at the very
// end of the next item, until that register frees.
// Reset (arst_n low) clears the controller history (last error, rate,
// surface and the sign integral), restores the register defaults and drops
// out_valid.
`default_nettype none
module super_twisting_smc_step_core #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [DATA_WIDTH-1:0]      target_value,
	input  wire logic signed [DATA_WIDTH-1:0]      measured_value,
	input  wire logic [stsmc_pkg::UCFG_W-1:0]      output_limit,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [DATA_WIDTH-1:0]           drive_value,
	input  wire logic                              cfg_we,
	input  wire logic [stsmc_pkg::CFG_IW-1:0]      cfg_index,
	input  wire logic [stsmc_pkg::CFG_DW-1:0]      cfg_data
);
	// square-root unit runs one bit pair per cycle over the shifted radicand
	localparam int SQ_STEPS = (DATA_WIDTH + FRAC_BITS + 1) / 2;

	stsmc_pkg::cmd_t cmd;
	stsmc_pkg::sts_t sts;

	// sequencer: owns handshakes, step order and iteration counts
	stsmc_ctrl #(
		.FRAC_BITS (FRAC_BITS),
		.SQ_STEPS  (SQ_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: registers, shared multiplier, divider and root units
	stsmc_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.target_value   (target_value),
		.measured_value (measured_value),
		.output_limit   (output_limit),
		.drive_value    (drive_value)
	);
endmodule
`default_nettype wire

// ----- tb/sv/super_twisting_smc_step_core_test.sv -----
`default_nettype none

// Predicts the drive for each transferred control step and holds the queue of
// expected drives. Tracks its own copy of the registers and the controller
// history (error, rate, surface, sign integral).
class stsmc_scoreboard;
	bit     mode;
	longint slope, soften, period, inv_period, rgain, igain;
	longint prev_err, prev_rate, prev_surf, sgn_integ;
	longint drive_q[$];
	int     mismatches;

	function new();
		mode = 0; slope = 65536; soften = 655; period = 65;
		inv_period = 65536000; rgain = 65536; igain = 72090;
		prev_err = 0; prev_rate = 0; prev_surf = 0; sgn_integ = 0;
		mismatches = 0;
	endfunction

	function void set_reg(stsmc_pkg::cfg_reg_t idx, logic [31:0] data);
		case (idx)
			stsmc_pkg::REG_MODE:   mode = data[0];
			stsmc_pkg::REG_SLOPE:  slope = longint'($signed(data));
			stsmc_pkg::REG_SOFTEN: soften = longint'(data[30:0]);
			stsmc_pkg::REG_PERIOD: period = longint'(data[30:0]);
			stsmc_pkg::REG_INVPER: inv_period = longint'(data[30:0]);
			stsmc_pkg::REG_RGAIN:  rgain = longint'(data[30:0]);
			stsmc_pkg::REG_IGAIN:  igain = longint'($signed(data));
			default: ;
		endcase
	endfunction

	static function longint sat(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	static function logic [63:0] magn(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	// product, magnitude truncated after the shift, sign applied last
	static function longint fx_mul(longint a, longint b, int sh, int w);
		logic [127:0] p;
		longint m;
		p = {64'd0, magn(a)} * {64'd0, magn(b)};
		p = p >> sh;
		m = (p > (128'd1 << 62)) ? (longint'(1) <<< 62) : longint'(p[63:0]);
		return sat(((a < 0) != (b < 0)) ? -m : m, w);
	endfunction

	function longint soft_sign(longint x);
		logic [63:0] r, d, q;
		r = magn(x);
		d = r + 64'(soften);
		q = 0;
		if (d == 0) return 0;
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
		end
		return (x < 0) ? -longint'(q) : longint'(q);
	endfunction

	static function longint fx_sqrt(logic [63:0] v);
		logic [63:0] n, rem, root, trial;
		n = v << 16;
		rem = 0;
		root = 0;
		for (int i = 62; i >= 0; i -= 2) begin
			rem = (rem << 2) | ((n >> i) & 64'd3);
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return longint'(root);
	endfunction

	function void note_step(logic signed [31:0] tgt, logic signed [31:0] meas,
			logic [30:0] lim_in);
		longint err, rate, surf, gs, force_t, smooth, drive, lim, acc, t2, l2, t3;
		lim = longint'(lim_in);
		err = sat(longint'(tgt) - longint'(meas), 32);
		rate = fx_mul(sat(err - prev_err, 32), inv_period, 16, 32);
		if (!mode) begin
			surf = sat(rate + fx_mul(slope, err, 16, 32), 32);
		end else begin
			acc = fx_mul(sat(rate - prev_rate, 32), inv_period, 16, 32);
			t2 = sat(2 * fx_mul(slope, rate, 16, 32), 32);
			l2 = fx_mul(slope, slope, 16, 32);
			t3 = fx_mul(l2, err, 16, 32);
			surf = sat(sat(acc + t2, 32) + t3, 32);
		end
		gs = soft_sign(surf);
		// trapezoid: half the period folded into the extra shift
		sgn_integ = sat(sgn_integ + fx_mul(soft_sign(prev_surf) + gs, period, 17, 40), 40);
		force_t = fx_mul(fx_mul(rgain, fx_sqrt(magn(surf)), 16, 32), gs, 16, 32);
		smooth = fx_mul(igain, sgn_integ, 16, 32);
		drive = sat(force_t + smooth, 32);
		if (drive >= lim) drive = lim;
		else if (drive <= -lim) drive = -lim;
		prev_err = err;
		prev_surf = surf;
		prev_rate = rate;
		drive_q.push_back(sat(drive, 32));
	endfunction

	function void check_drive(logic signed [31:0] got);
		longint want;
		if (drive_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected drive transfer: %0d", got);
			return;
		end
		want = drive_q.pop_front();
		if (longint'(got) != want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("drive_value: expected %0d, got %0d", want, got);
		end
	endfunction
endclass

module super_twisting_smc_step_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int LONG_HOLD   = 400;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] target_value = '0;
	logic signed [31:0] measured_value = '0;
	logic [30:0]        output_limit = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] drive_value;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	stsmc_scoreboard sb = new();
	int  cycles = 0;
	bit  hold_req = 0;     // main asks the receiver for one long hold-off
	bit  no_gaps = 0;      // stretch with back-to-back transfers
	logic signed [31:0] track_base = '0;

	super_twisting_smc_step_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.target_value(target_value), .measured_value(measured_value),
		.output_limit(output_limit),
		.out_valid(out_valid), .out_ready(out_ready), .drive_value(drive_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70) return $urandom_range(0, 2);
		if (p < 95) return $urandom_range(3, 12);
		return $urandom_range(20, 90);
	endfunction

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random back-pressure plus one long hold-off on request
	initial begin : receiver
		int hold_left, low_left;
		hold_left = 0;
		low_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (low_left > 0) begin
				out_ready <= 1'b0;
				low_left--;
			end else begin
				out_ready <= 1'b1;
				if (!no_gaps && $urandom_range(0, 99) < 30) low_left = gap_len();
			end
		end
	end

	// output monitor
	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check_drive(drive_value);

	task automatic write_reg(stsmc_pkg::cfg_reg_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one input transfer; valid held until the block takes it
	task automatic send_step(logic signed [31:0] tgt, logic signed [31:0] meas,
			logic [30:0] lim);
		@(negedge clk);
		in_valid <= 1'b1;
		target_value <= tgt;
		measured_value <= meas;
		output_limit <= lim;
		forever begin
			@(posedge clk);
			if (in_ready) break;
		end
		sb.note_step(tgt, meas, lim);
	endtask

	task automatic send_gap();
		int g;
		g = no_gaps ? 0 : gap_len();
		if (g > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	// idle point: input dropped and every expected drive has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.drive_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_signed();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'd0;
			3: return $urandom();
			default: return 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
		endcase
	endfunction

	function automatic logic [31:0] pick_unsigned(logic [31:0] typical);
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = 32'h7FFF_FFFF;
			1: v = 32'd1;
			2: v = 32'd0;
			3: v = $urandom();
			default: v = typical;
		endcase
		// top bit is outside the register; flip it to see it dropped
		v[31] = $urandom_range(0, 1);
		return v;
	endfunction

	task automatic random_config();
		logic [31:0] m;
		m = $urandom();
		write_reg(stsmc_pkg::REG_MODE, m);
		write_reg(stsmc_pkg::REG_SLOPE, pick_signed());
		write_reg(stsmc_pkg::REG_SOFTEN, pick_unsigned($urandom_range(1, 70000)));
		write_reg(stsmc_pkg::REG_PERIOD, pick_unsigned($urandom_range(1, 700)));
		write_reg(stsmc_pkg::REG_INVPER, pick_unsigned($urandom_range(65536, 65536000)));
		write_reg(stsmc_pkg::REG_RGAIN, pick_unsigned($urandom_range(0, 4 * 65536)));
		write_reg(stsmc_pkg::REG_IGAIN, pick_signed());
		end_writes();
	endtask

	// mostly a loop tracking a slowly moving setpoint, the rest noise
	task automatic random_step();
		logic signed [31:0] t, m;
		logic [30:0] l;
		int p;
		p = $urandom_range(0, 99);
		if (p < 65) begin
			track_base = track_base + 32'($signed($urandom_range(0, 8192)) - 4096);
			t = track_base;
			m = track_base + 32'($signed($urandom_range(0, 2048)) - 1024);
		end else if (p < 85) begin
			t = $urandom();
			m = $urandom();
		end else begin
			t = pick_signed();
			m = pick_signed();
		end
		case ($urandom_range(0, 4))
			0: l = 31'h7FFF_FFFF;
			1: l = 31'd0;
			2: l = 31'($urandom());
			default: l = 31'($urandom_range(0, 64 * 65536));
		endcase
		send_step(t, m, l);
		send_gap();
	endtask

	initial begin : main
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: register defaults, speed surface
		send_step(32'd0, 32'd0, 31'h7FFF_FFFF);
		send_step(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
		send_step(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
		send_step(32'd65536, 32'd0, 31'd0);
		send_step(32'h8000_0000, 32'd0, 31'd65536);
		send_step(32'd131072, 32'd65536, 31'd1000);
		wait_drained();

		// position surface, extreme slope and gains
		write_reg(stsmc_pkg::REG_MODE, 32'hFFFF_FFFE);   // bit 0 clear: still speed mode
		write_reg(stsmc_pkg::REG_MODE, 32'd1);
		write_reg(stsmc_pkg::REG_SLOPE, 32'h8000_0000);
		write_reg(stsmc_pkg::REG_RGAIN, 32'h7FFF_FFFF);
		write_reg(stsmc_pkg::REG_IGAIN, 32'h8000_0000);
		end_writes();
		send_step(32'd65536, 32'd0, 31'h7FFF_FFFF);
		send_step(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
		send_step(32'd0, 32'd1, 31'd5);
		send_step(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
		wait_drained();

		// zero softening with a zero surface, and zero period registers
		write_reg(stsmc_pkg::REG_SOFTEN, 32'd0);
		write_reg(stsmc_pkg::REG_PERIOD, 32'd0);
		write_reg(stsmc_pkg::REG_INVPER, 32'd0);
		write_reg(stsmc_pkg::REG_SLOPE, 32'd0);
		write_reg(stsmc_pkg::REG_IGAIN, 32'h7FFF_FFFF);
		end_writes();
		send_step(32'd0, 32'd0, 31'h7FFF_FFFF);
		send_step(32'd12345, 32'd12345, 31'h7FFF_FFFF);
		send_step(32'd65536, 32'd0, 31'h7FFF_FFFF);
		wait_drained();
		write_reg(stsmc_pkg::REG_PERIOD, 32'h7FFF_FFFF);
		write_reg(stsmc_pkg::REG_INVPER, 32'h7FFF_FFFF);
		write_reg(stsmc_pkg::REG_SOFTEN, 32'h7FFF_FFFF);
		end_writes();
		wait_drained();
		send_step(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
		send_step(32'h8000_0000, 32'h7FFF_FFFF, 31'h4000_0000);
		wait_drained();

		// random phases, each under fresh settings
		for (int ph = 0; ph < 9; ph++) begin
			random_config();
			no_gaps = (ph % 4 == 2);
			if (ph == 1) hold_req = 1;   // block fills up behind a stalled receiver
			for (int i = 0; i < 210; i++) random_step();
			wait_drained();
		end
		no_gaps = 0;

		repeat (150) @(posedge clk);
		if (sb.mismatches == 0 && sb.drive_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

`default_nettype wire
